// File: hdl/icr_pkg.sv
// Shared widths and beat payload types for the instruction cache refill core.
`default_nettype none

package icr_pkg;

   localparam int ADDR_WIDTH = 32;
   localparam int DATA_WIDTH = 32;
   // Stored tags never carry more than this many bits.
   localparam int TAG_LIMIT  = 20;
   localparam int STATE_WIDTH = 2;

   typedef struct packed {
      logic                  fetch_valid;
      logic [ADDR_WIDTH-1:0] fetch_address;
      logic                  mem_ack;
      logic [DATA_WIDTH-1:0] mem_word;
   } req_payload_type;

   typedef struct packed {
      logic                   hit;
      logic                   stall_res;
      logic [DATA_WIDTH-1:0]  instruction;
      logic [ADDR_WIDTH-1:0]  refill_address;
      logic                   refill_request;
      logic [STATE_WIDTH-1:0] controller_state;
   } rsp_payload_type;

endpackage

`default_nettype wire

// File: hdl/icr_stream_if.sv
// Valid/ready channel carrying one payload beat per handshake.
`default_nettype none

interface icr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/direct_mapped_icache_refill_core.sv
// Direct-mapped instruction cache with line refill controller, top level.
//
// Each beat on req_chan is one cycle of the fetch and memory pins: fetch_valid,
// fetch_address, mem_ack and mem_word. For every accepted beat exactly one beat
// leaves on rsp_chan with hit, stall_res, instruction, refill_address,
// refill_request and controller_state, in the order the beats came in.
// An accepted beat passes the lookup stage, where the registered tag and word
// reads meet the valid bits, then the output register. Throughput is one beat
// per cycle while rsp_ready is high, set by the single lookup stage and the one
// write port of each store; a refill write to the line being read by the next
// beat is forwarded into the read register.
// Reset clears the valid bits, the controller state and the held instruction
// and refill address; the tag and data stores are not cleared and a line is
// only read once a refill has made it valid.
// When rsp_ready is low the output register holds its beat, the lookup stage
// holds the next one with no state update, and req_ready drops once both are
// full. LINE_COUNT and WORDS_PER_LINE must be powers of two.
`default_nettype none

module direct_mapped_icache_refill_core #(
   parameter int LINE_COUNT     = 256,
   parameter int WORDS_PER_LINE = 4
) (
   input  wire           clock,
   input  wire           reset,
   icr_stream_if.sink    req_chan,
   icr_stream_if.source  rsp_chan
);
   import icr_pkg::*;

   localparam int WORD_BITS   = $clog2(WORDS_PER_LINE);
   localparam int INDEX_BITS  = $clog2(LINE_COUNT);
   localparam int OFFSET_BITS = WORD_BITS + 2;
   localparam int SLOT_BITS   = INDEX_BITS + WORD_BITS;
   localparam int SLOT_COUNT  = LINE_COUNT * WORDS_PER_LINE;
   localparam int ADDR_TAG_BITS = ADDR_WIDTH - OFFSET_BITS - INDEX_BITS;
   localparam int TAG_BITS = (ADDR_TAG_BITS > TAG_LIMIT) ? TAG_LIMIT : ADDR_TAG_BITS;

   typedef enum logic [STATE_WIDTH-1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_UPDT = 2'd2
   } phase_type;

   // Stores
   logic [TAG_BITS-1:0]   tag_mem  [LINE_COUNT];
   logic [DATA_WIDTH-1:0] line_mem [SLOT_COUNT];
   logic [LINE_COUNT-1:0] valid_ff, valid_in;

   // Lookup stage
   logic                  s1_valid_ff;
   logic                  s1_fetch_ff;
   logic [ADDR_WIDTH-1:0] s1_addr_ff;
   logic                  s1_ack_ff;
   logic [DATA_WIDTH-1:0] s1_word_ff;
   logic [TAG_BITS-1:0]   tag_rd_ff;
   logic [DATA_WIDTH-1:0] line_rd_ff;

   // Controller state
   phase_type             phase_ff, phase_in;
   logic [INDEX_BITS-1:0] pend_index_ff, pend_index_in;
   logic [TAG_BITS-1:0]   pend_tag_ff, pend_tag_in;
   logic [WORD_BITS-1:0]  count_ff, count_in;
   logic [DATA_WIDTH-1:0] held_instr_ff, held_instr_in;
   logic [ADDR_WIDTH-1:0] held_addr_ff, held_addr_in;

   // Output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   logic                  req_fire;
   logic                  s1_adv;
   logic [INDEX_BITS-1:0] in_index;
   logic [SLOT_BITS-1:0]  in_slot;
   logic [INDEX_BITS-1:0] s1_index;
   logic [TAG_BITS-1:0]   s1_tag;
   logic                  s1_hit;
   logic                  request;
   logic                  tag_we_c, line_we_c;
   logic                  tag_we, line_we;
   logic [SLOT_BITS-1:0]  wr_slot;

   assign s1_adv        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_fire      = req_chan.valid && req_chan.ready;

   assign in_index = req_chan.payload.fetch_address[OFFSET_BITS +: INDEX_BITS];
   assign in_slot  = req_chan.payload.fetch_address[2 +: SLOT_BITS];
   assign s1_index = s1_addr_ff[OFFSET_BITS +: INDEX_BITS];
   assign s1_tag   = s1_addr_ff[OFFSET_BITS + INDEX_BITS +: TAG_BITS];
   assign s1_hit   = valid_ff[s1_index] && (tag_rd_ff == s1_tag);
   assign wr_slot  = {pend_index_ff, count_ff};

   // Next controller state for the beat in the lookup stage. Hit is judged
   // against the stores before this beat's own update.
   always_comb begin
      phase_in      = phase_ff;
      pend_index_in = pend_index_ff;
      pend_tag_in   = pend_tag_ff;
      count_in      = count_ff;
      held_addr_in  = held_addr_ff;
      held_instr_in = s1_hit ? line_rd_ff : held_instr_ff;
      valid_in      = valid_ff;
      request       = 1'b0;
      tag_we_c      = 1'b0;
      line_we_c     = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (s1_fetch_ff && !s1_hit) begin
               phase_in      = PH_WAIT;
               held_addr_in  = {s1_addr_ff[ADDR_WIDTH-1:OFFSET_BITS], OFFSET_BITS'(0)};
               pend_index_in = s1_index;
               pend_tag_in   = s1_tag;
               count_in      = '0;
               request       = 1'b1;
            end
         end
         PH_WAIT: begin
            if (s1_ack_ff) begin
               phase_in                = PH_UPDT;
               line_we_c               = 1'b1;
               tag_we_c                = 1'b1;
               count_in                = count_ff + WORD_BITS'(1);
               valid_in[pend_index_ff] = 1'b0;
            end else begin
               request = 1'b1;
            end
         end
         PH_UPDT: begin
            if (!s1_ack_ff) begin
               phase_in                = PH_IDLE;
               valid_in[pend_index_ff] = 1'b1;
            end else begin
               line_we_c = 1'b1;
               count_in  = count_ff + WORD_BITS'(1);
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign tag_we  = s1_adv && tag_we_c;
   assign line_we = s1_adv && line_we_c;

   // Stores with registered reads; a write landing on the address being
   // read in the same cycle is passed straight to the read register.
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[pend_index_ff] <= pend_tag_ff;
      end
      if (line_we) begin
         line_mem[wr_slot] <= s1_word_ff;
      end
      if (req_fire) begin
         if (tag_we && (pend_index_ff == in_index)) begin
            tag_rd_ff <= pend_tag_ff;
         end else begin
            tag_rd_ff <= tag_mem[in_index];
         end
         if (line_we && (wr_slot == in_slot)) begin
            line_rd_ff <= s1_word_ff;
         end else begin
            line_rd_ff <= line_mem[in_slot];
         end
      end
   end

   // Lookup stage payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_fetch_ff <= req_chan.payload.fetch_valid;
         s1_addr_ff  <= req_chan.payload.fetch_address;
         s1_ack_ff   <= req_chan.payload.mem_ack;
         s1_word_ff  <= req_chan.payload.mem_word;
      end
   end

   // Controller state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         pend_index_ff <= '0;
         pend_tag_ff   <= '0;
         count_ff      <= '0;
         held_instr_ff <= '0;
         held_addr_ff  <= '0;
         valid_ff      <= '0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            phase_ff      <= phase_in;
            pend_index_ff <= pend_index_in;
            pend_tag_ff   <= pend_tag_in;
            count_ff      <= count_in;
            held_instr_ff <= held_instr_in;
            held_addr_ff  <= held_addr_in;
            valid_ff      <= valid_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_payload_ff.hit              <= s1_hit;
         rsp_payload_ff.stall_res        <= !s1_hit;
         rsp_payload_ff.instruction      <= held_instr_in;
         rsp_payload_ff.refill_address   <= held_addr_in;
         rsp_payload_ff.refill_request   <= request;
         rsp_payload_ff.controller_state <= phase_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

`default_nettype wire
